// ===== hw/rtl/crc8_framed_packet_receiver_defines.svh =====
// assertion macros shared by the framed receiver rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef CRC8_FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define CRC8_FRAMED_PACKET_RECEIVER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CRC8FR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CRC8FR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/crc8fr_pkg.sv =====
// shared constants and crc helper for the framed receiver
// no dependencies
package crc8fr_pkg;

  localparam int unsigned MaxLenDefault = 64;

  localparam logic [7:0] HdrSoh  = 8'h10;
  localparam logic [7:0] HdrStx  = 8'h20;
  localparam logic [7:0] HdrMask = 8'hF0;
  localparam logic [7:0] CrcPoly = 8'h8C;

  // result kinds
  localparam logic [1:0] KindData   = 2'd0;
  localparam logic [1:0] KindCrcErr = 2'd1;
  localparam logic [1:0] KindOwnMsg = 2'd2;

  // reflected crc-8, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CrcPoly;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/crc8fr_in_if.sv =====
// input channel of the framed receiver: one bus byte per transaction
// no dependencies
interface crc8fr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/crc8fr_out_if.sv =====
// result channel of the framed receiver: one result per transaction
// no dependencies
interface crc8fr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input last, output ready);
endinterface

// ===== hw/rtl/crc8fr_ram.sv =====
// generic single-port ram with registered read data
// no dependencies
module crc8fr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/crc8_framed_packet_receiver.sv =====
// framed packet receiver with crc-8 check and payload buffer
// depends on crc8fr_pkg, crc8fr_in_if, crc8fr_out_if, crc8fr_ram and the defines header
//
// usage:
//   in_i takes one received bus byte per transaction. while hunting, bytes shift
//   through a four-byte header window; a header is start byte (upper nibble 1),
//   expected crc, length, then 0x20. lengths of zero or MAX_LEN and above are
//   skipped. payload bytes go into a single-port ram while the crc-8 runs.
//   out_o gives the frame verdict: a good frame streams its payload (kind data,
//   last on the final byte), an own message gives one rejection result, a crc
//   mismatch gives one error result.
//   the apb port holds node_id (address 0) and id_assigned (address 4); write it
//   only while the block is idle.
// timing:
//   header and payload bytes are taken one per cycle. after the last payload byte
//   the input stalls for the verdict state and the readout. an error or rejection
//   result enters the output register from the verdict state once it is free; a
//   good frame's verdict state starts the ram read of byte 0, then one byte per
//   cycle follows, paced by the single ram port, while the sink takes them.
// reset and stalls:
//   reset clears the header window, crc and frame state; the ram is not cleared.
//   a stalled sink holds the output register, which holds the readout and keeps
//   the input blocked until the final result is taken into it.
module crc8_framed_packet_receiver #(
  parameter int unsigned MAX_LEN = crc8fr_pkg::MaxLenDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  crc8fr_in_if.sink           in_i,
  crc8fr_out_if.source        out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import crc8fr_pkg::*;

  `include "crc8_framed_packet_receiver_defines.svh"

  localparam int unsigned LEN_W = $clog2(MAX_LEN);
  localparam logic [7:0] LenLimit = 8'(MAX_LEN);

  // sequencer codes
  localparam logic [1:0] ST_RX    = 2'd0;  // hunting or taking payload
  localparam logic [1:0] ST_JUDGE = 2'd1;  // verdict, first ram read
  localparam logic [1:0] ST_LOAD  = 2'd2;  // payload readout

  // configuration registers
  logic [7:0] node_id_q;
  logic       id_assigned_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q     <= '0;
      id_assigned_q <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        id_assigned_q <= pwdata[0];
      end else begin
        node_id_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = paddr[2] ? {31'b0, id_assigned_q} : {24'b0, node_id_q};

  // frame state
  logic [1:0]       state_q, state_d;
  logic [3:0][7:0]  win_q, win_d;       // index 0 is the oldest byte
  logic             in_payload_q, in_payload_d;
  logic [LEN_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]       exp_crc_q, exp_crc_d;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       first_q, first_d;   // first payload byte, for own-id check
  logic             crc_ok_q, crc_ok_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_kind_q, out_kind_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_free;
  logic       out_load;

  // ram port
  logic             ram_we;
  logic             ram_re;
  logic [LEN_W-1:0] ram_addr;
  logic [7:0]       ram_rdata;

  logic             in_fire;
  logic             hdr_hit;
  logic [7:0]       crc_next;
  logic [LEN_W-1:0] pos_next;
  logic [LEN_W-1:0] rd_next;
  logic             own_msg;

  assign in_i.ready = (state_q == ST_RX);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_free   = ~out_valid_q | out_o.ready;

  assign crc_next = crc8_step(crc_q, in_i.rx_byte);
  assign pos_next = pos_q + LEN_W'(1);
  assign rd_next  = rd_idx_q + LEN_W'(1);
  assign own_msg  = id_assigned_q & (first_q == node_id_q);

  // header seen once the new byte is shifted in: win_q[1] becomes the oldest
  assign hdr_hit = ((win_q[1] & HdrMask) == HdrSoh) && (in_i.rx_byte == HdrStx)
                   && (win_q[3] != 8'd0) && (win_q[3] < LenLimit);

  always_comb begin
    state_d      = state_q;
    win_d        = win_q;
    in_payload_d = in_payload_q;
    pos_d        = pos_q;
    len_d        = len_q;
    rd_idx_d     = rd_idx_q;
    exp_crc_d    = exp_crc_q;
    crc_d        = crc_q;
    first_d      = first_q;
    crc_ok_d     = crc_ok_q;
    out_load     = 1'b0;
    out_kind_d   = out_kind_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = pos_q;

    case (state_q)
      ST_RX: begin
        if (in_fire) begin
          if (!in_payload_q) begin
            win_d = {in_i.rx_byte, win_q[3:1]};
            if (hdr_hit) begin
              exp_crc_d    = win_q[2];
              len_d        = win_q[3][LEN_W-1:0];
              crc_d        = crc8_step(8'd0, win_q[3]);
              pos_d        = '0;
              in_payload_d = 1'b1;
            end
          end else begin
            ram_we = 1'b1;
            crc_d  = crc_next;
            pos_d  = pos_next;
            if (pos_q == '0) begin
              first_d = in_i.rx_byte;
            end
            if (pos_next == len_q) begin
              in_payload_d = 1'b0;
              pos_d        = '0;
              crc_ok_d     = (crc_next == exp_crc_q);
              state_d      = ST_JUDGE;
            end
          end
        end
      end
      ST_JUDGE: begin
        if (crc_ok_q && !own_msg) begin
          // start the readout at byte 0
          ram_re   = 1'b1;
          ram_addr = '0;
          rd_idx_d = '0;
          state_d  = ST_LOAD;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = crc_ok_q ? KindOwnMsg : KindCrcErr;
          out_byte_d = 8'd0;
          out_last_d = 1'b1;
          state_d    = ST_RX;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KindData;
          out_byte_d = ram_rdata;
          out_last_d = (rd_next == len_q);
          if (rd_next == len_q) begin
            state_d = ST_RX;
          end else begin
            // fetch the next byte while this one goes out
            ram_re   = 1'b1;
            ram_addr = rd_next;
            rd_idx_d = rd_next;
          end
        end
      end
      default: begin
        state_d = ST_RX;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RX;
      win_q        <= '0;
      in_payload_q <= 1'b0;
      pos_q        <= '0;
      len_q        <= '0;
      rd_idx_q     <= '0;
      exp_crc_q    <= '0;
      crc_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      win_q        <= win_d;
      in_payload_q <= in_payload_d;
      pos_q        <= pos_d;
      len_q        <= len_d;
      rd_idx_q     <= rd_idx_d;
      exp_crc_q    <= exp_crc_d;
      crc_q        <= crc_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    first_q    <= first_d;
    crc_ok_q   <= crc_ok_d;
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  crc8fr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (in_i.rx_byte),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.payload_byte = out_byte_q;
  assign out_o.last         = out_last_q;

  // a pending result is never overwritten
  `CRC8FR_ASSERT(a_no_overwrite, out_load && out_valid_q, out_o.ready, "result overwritten")
  // payload reception only happens in the receive state
  `CRC8FR_ASSERT(a_payload_in_rx, in_payload_q, state_q == ST_RX, "payload outside rx")
  // the write position stays inside the frame
  `CRC8FR_ASSERT(a_pos_in_frame, in_payload_q, (len_q != '0) && (pos_q < len_q),
                 "payload position out of frame")
  // the readout index stays inside the frame
  `CRC8FR_ASSERT(a_rd_in_frame, state_q == ST_LOAD, rd_idx_q < len_q, "readout out of frame")
  // the last payload byte hands over to the verdict
  `CRC8FR_ASSERT_NEXT(a_end_to_judge, in_fire && in_payload_q && (pos_next == len_q),
                      state_q == ST_JUDGE && !in_payload_q, "frame end missed")

endmodule

// ===== tb/crc8_framed_packet_receiver_tb.sv =====
// self-checking testbench for the crc-8 framed packet receiver
// depends on crc8fr_pkg, crc8fr_in_if, crc8fr_out_if and crc8_framed_packet_receiver
module crc8_framed_packet_receiver_tb;
  import crc8fr_pkg::*;

  // apb register map, 32-bit registers at 4-byte spacing
  localparam logic [2:0] RegNodeIdAddr     = 3'd0;
  localparam logic [2:0] RegIdAssignedAddr = 3'd4;

  localparam int unsigned MaxLen = MaxLenDefault;
  localparam int SettleCycles   = 8;
  // cycles with no transaction on either channel before the run is given up
  localparam int WatchdogLimit  = 2000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       last;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crc8fr_in_if  in_bus ();
  crc8fr_out_if out_bus ();

  crc8_framed_packet_receiver DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // frame predictor: mirror of the receiver state and its register copies
  // ---------------------------------------------------------------------------
  logic [7:0] hdr_win [4] = '{default: 8'h00};
  logic       in_frame    = 1'b0;
  logic [5:0] pay_pos     = 6'd0;
  logic [5:0] pay_len     = 6'd0;
  logic [7:0] want_crc    = 8'h00;
  logic [7:0] run_crc     = 8'h00;
  logic [7:0] pay_mem [64];
  logic [7:0] own_node_id    = 8'h00;
  logic       own_id_enabled = 1'b0;

  // results the receiver still owes, oldest first
  frame_result_t frame_results_q [$];
  // bus bytes waiting to be sent, front is the one on the wire
  logic [7:0]    bus_bytes [$];

  int good_frames     = 0;
  int crc_err_frames  = 0;
  int own_frames      = 0;
  int bytes_accepted  = 0;
  int bytes_seen      = 0;
  int results_checked = 0;
  int error_count     = 0;
  int stall_cycles    = 0;
  int bytes_queued    = 0;
  bit chain_ok        = 1'b0;
  int send_idle_pct;
  int recv_idle_pct;

  // dallas/maxim crc-8, lsb first, one data bit at a time
  function automatic logic [7:0] crc8_maxim(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // one accepted bus byte: header hunt or payload capture, verdict at frame end
  task automatic receive_bus_byte(input logic [7:0] b);
    frame_result_t r;
    if (!in_frame) begin
      // window only shifts while hunting, never cleared
      hdr_win[0] = hdr_win[1];
      hdr_win[1] = hdr_win[2];
      hdr_win[2] = hdr_win[3];
      hdr_win[3] = b;
      if (((hdr_win[0] & HdrMask) == HdrSoh) && (hdr_win[3] == HdrStx) &&
          (hdr_win[2] != 8'h00) && (hdr_win[2] < MaxLen)) begin
        want_crc = hdr_win[1];
        pay_len  = hdr_win[2][5:0];
        // length byte is part of the checked data
        run_crc  = crc8_maxim(8'h00, hdr_win[2]);
        pay_pos  = 6'd0;
        in_frame = 1'b1;
      end
    end else begin
      pay_mem[pay_pos] = b;
      run_crc = crc8_maxim(run_crc, b);
      pay_pos = pay_pos + 6'd1;
      if (pay_pos == pay_len) begin
        in_frame = 1'b0;
        pay_pos  = 6'd0;
        if (run_crc != want_crc) begin
          r = '{kind: KindCrcErr, payload_byte: 8'h00, last: 1'b1};
          frame_results_q.push_back(r);
          crc_err_frames++;
        end else if (own_id_enabled && (pay_mem[0] == own_node_id)) begin
          // own message: a single rejection instead of the payload
          r = '{kind: KindOwnMsg, payload_byte: 8'h00, last: 1'b1};
          frame_results_q.push_back(r);
          own_frames++;
        end else begin
          for (int i = 0; i < pay_len; i++) begin
            r = '{kind: KindData, payload_byte: pay_mem[i], last: (i == pay_len - 1)};
            frame_results_q.push_back(r);
          end
          good_frames++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: inputs change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic       drive_valid;
    logic [7:0] drive_byte;
    drive_valid = 1'b0;
    drive_byte  = 8'($urandom_range(255));
    if (!rst_ni) begin
      drive_valid = 1'b0;
    end else if (in_bus.valid && (bytes_accepted == bytes_seen)) begin
      // byte still on the wire, hold it until taken
      drive_valid = 1'b1;
      drive_byte  = in_bus.rx_byte;
    end else if ((bus_bytes.size() != 0) && ($urandom_range(99) >= send_idle_pct)) begin
      drive_valid = 1'b1;
      drive_byte  = bus_bytes[0];
    end
    bytes_seen = bytes_accepted;
    in_bus.valid   <= drive_valid;
    in_bus.rx_byte <= drive_byte;
    out_bus.ready  <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: both channels sampled on the rising edge, plus the watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    frame_result_t want;
    logic          moved;
    moved = 1'b0;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      receive_bus_byte(in_bus.rx_byte);
      bus_bytes.delete(0);
      bytes_accepted++;
      moved = 1'b1;
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      moved = 1'b1;
      results_checked++;
      if (frame_results_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual kind %0d byte %h last %b",
                 $time, out_bus.kind, out_bus.payload_byte, out_bus.last);
      end else begin
        want = frame_results_q.pop_front();
        if (out_bus.kind !== want.kind) begin
          error_count++;
          $display("%0t: kind mismatch, expected %0d, actual %0d",
                   $time, want.kind, out_bus.kind);
        end
        if (out_bus.payload_byte !== want.payload_byte) begin
          error_count++;
          $display("%0t: payload_byte mismatch, expected %h, actual %h",
                   $time, want.payload_byte, out_bus.payload_byte);
        end
        if (out_bus.last !== want.last) begin
          error_count++;
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, want.last, out_bus.last);
        end
      end
    end
    if (moved) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, WatchdogLimit, frame_results_q.size());
      $display("** crc8_framed_packet_receiver: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    bus_bytes.push_back(b);
    bytes_queued++;
  endtask

  // apb write: setup cycle, then access cycle; pready is always high
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (addr)
      RegNodeIdAddr: begin
        own_node_id = data[7:0];
      end
      RegIdAssignedAddr: begin
        own_id_enabled = data[0];
      end
      default: begin
      end
    endcase
  endtask

  // mostly short frames, a few long ones
  function automatic int pick_frame_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return $urandom_range(1, 8);
    end else if (r < 95) begin
      return $urandom_range(9, 31);
    end
    return $urandom_range(32, MaxLen - 1);
  endfunction

  // full frame, or a chained one whose header reuses the previous header's
  // length and stx bytes (start nibble and crc come from the kept window)
  task automatic queue_frame(input int len, input bit bad_crc, input bit own_first,
                             input bit chained);
    logic [7:0] pay [$];
    logic [7:0] crc;
    logic [7:0] flip;
    logic [7:0] b;
    flip = bad_crc ? 8'($urandom_range(1, 255)) : 8'h00;
    crc  = crc8_maxim(8'h00, 8'(len));
    for (int k = 0; k < len; k++) begin
      b = (k == 0 && own_first) ? own_node_id : 8'($urandom_range(255));
      if (k == len - 1 && chained) begin
        // chained header carries stx as its crc, so steer the last byte there
        for (int c = 0; c < 256; c++) begin
          if (crc8_maxim(crc, 8'(c)) == (HdrStx ^ flip)) begin
            b = 8'(c);
          end
        end
      end
      pay.push_back(b);
      crc = crc8_maxim(crc, b);
    end
    if (!chained) begin
      queue_byte({4'h1, 4'($urandom_range(15))});
      queue_byte(crc ^ flip);
    end
    queue_byte(8'(len));
    queue_byte(HdrStx);
    foreach (pay[k]) begin
      queue_byte(pay[k]);
    end
    chain_ok = (len >= 16) && (len <= 31);
  endtask

  // random traffic: mostly well-formed frames, some broken headers and noise
  task automatic queue_random(input int budget);
    int start;
    int r;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      r = $urandom_range(99);
      if (chain_ok && r < 40) begin
        queue_frame($urandom_range(1, 31), ($urandom_range(99) < 20), 1'b0, 1'b1);
      end else if (r < 60) begin
        queue_frame(pick_frame_len(), 1'b0, ($urandom_range(99) < 25), 1'b0);
      end else if (r < 74) begin
        queue_frame(pick_frame_len(), 1'b1, ($urandom_range(99) < 25), 1'b0);
      end else if (r < 86) begin
        // header with a length of zero or too large: skipped
        queue_byte({4'h1, 4'($urandom_range(15))});
        queue_byte(8'($urandom_range(255)));
        queue_byte(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(MaxLen, 255)));
        queue_byte(HdrStx);
        chain_ok = 1'b0;
      end else begin
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(255)));
        chain_ok = 1'b0;
      end
    end
  endtask

  // sender stops until every owed result is in, then the block settles
  task automatic drain_results();
    while ((bus_bytes.size() != 0) || (frame_results_q.size() != 0)) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = 8'h00;
    out_bus.ready  = 1'b0;
    send_idle_pct  = 20;
    recv_idle_pct  = 55;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(RegNodeIdAddr, 32'h0000_005A);
    write_reg(RegIdAssignedAddr, 32'd1);

    // directed: zero length header is skipped
    queue_byte(8'h10);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(HdrStx);
    // length of MAX_LEN is skipped too
    queue_byte(8'h1F);
    queue_byte(8'hFF);
    queue_byte(8'(MaxLen));
    queue_byte(HdrStx);
    // a full one-byte frame with a good crc follows the skipped headers
    queue_byte(8'h1F);
    queue_byte(crc8_maxim(crc8_maxim(8'h00, 8'd1), 8'h00));
    queue_byte(8'd1);
    queue_byte(HdrStx);
    queue_byte(8'h00);
    // crc mismatch, then an own message with a good crc
    queue_frame(2, 1'b1, 1'b0, 1'b0);
    queue_frame(1, 1'b0, 1'b1, 1'b0);

    // phase one: busy sender, slow receiver, with a full drain halfway
    queue_random(20);
    drain_results();
    queue_random(20);
    drain_results();

    // phase two: slow sender, busy receiver, node id at its low end
    write_reg(RegNodeIdAddr, 32'h0000_0000);
    send_idle_pct = 55;
    recv_idle_pct = 20;
    queue_random(45);
    drain_results();

    // phase three: no idling, node id at its top, rejection off
    write_reg(RegNodeIdAddr, 32'h0000_00FF);
    write_reg(RegIdAssignedAddr, 32'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_frame(MaxLen - 1, 1'b0, 1'b1, 1'b0);
    queue_random(15);
    drain_results();

    $display("covered %0d bus bytes and %0d results under three idle mixes",
             bytes_accepted, results_checked);
    $display("frames: %0d good, %0d crc errors, %0d own messages rejected",
             good_frames, crc_err_frames, own_frames);
    if (error_count == 0) begin
      $display("** crc8_framed_packet_receiver: PASSED **");
    end else begin
      $display("** crc8_framed_packet_receiver: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/crc8fr_pkg.sv
hw/rtl/crc8fr_in_if.sv
hw/rtl/crc8fr_out_if.sv
hw/rtl/crc8fr_ram.sv
hw/rtl/crc8_framed_packet_receiver.sv
tb/crc8_framed_packet_receiver_tb.sv
